// ----- hw/rtl/b64c_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64c_pkg
// Shared types, constants and alphabet functions for the Base64 codec.
// ----------------------------------------------------------------------------
package b64c_pkg;

    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned SEXTET_W    = 6;
    localparam int unsigned MAX_RESULTS = 4;
    localparam int unsigned RES_IDX_W   = 2;
    localparam int unsigned RES_CNT_W   = 3;

    localparam logic [BYTE_W-1:0] PAD_CHAR   = 8'h3D;
    localparam logic [BYTE_W-1:0] PLUS_CHAR  = 8'h2B;
    localparam logic [BYTE_W-1:0] SLASH_CHAR = 8'h2F;

    typedef enum logic
    {
        MODE_ENCODE = 1'b0,
        MODE_DECODE = 1'b1
    } mode_t;

    typedef enum logic [1:0]
    {
        PHASE_0 = 2'd0,
        PHASE_1 = 2'd1,
        PHASE_2 = 2'd2,
        PHASE_3 = 2'd3
    } phase_t;

    typedef struct packed
    {
        logic                valid;
        logic [SEXTET_W-1:0] sextet;
    } sextet_lookup_t;

    // Per-transaction flags shared by every result of one input item.
    typedef struct packed
    {
        logic marker;
        logic bad;
        logic msg_end;
    } item_flags_t;

    function automatic logic [BYTE_W-1:0] sextet_to_char(input logic [SEXTET_W-1:0] v);
        logic [BYTE_W-1:0] c;
        if (v < 6'd26)
        begin
            c = 8'h41 + BYTE_W'(v);
        end
        else if (v < 6'd52)
        begin
            c = 8'h61 + BYTE_W'(v - 6'd26);
        end
        else if (v < 6'd62)
        begin
            c = 8'h30 + BYTE_W'(v - 6'd52);
        end
        else if (v == 6'd62)
        begin
            c = PLUS_CHAR;
        end
        else
        begin
            c = SLASH_CHAR;
        end
        return c;
    endfunction

    function automatic sextet_lookup_t char_to_sextet(input logic [BYTE_W-1:0] c);
        sextet_lookup_t r;
        r.valid  = 1'b1;
        r.sextet = '0;
        if (c >= 8'h41 && c <= 8'h5A)
        begin
            r.sextet = SEXTET_W'(c - 8'h41);
        end
        else if (c >= 8'h61 && c <= 8'h7A)
        begin
            r.sextet = SEXTET_W'(c - 8'h61 + 8'd26);
        end
        else if (c >= 8'h30 && c <= 8'h39)
        begin
            r.sextet = SEXTET_W'(c - 8'h30 + 8'd52);
        end
        else if (c == PLUS_CHAR)
        begin
            r.sextet = 6'd62;
        end
        else if (c == SLASH_CHAR)
        begin
            r.sextet = 6'd63;
        end
        else
        begin
            r.valid = 1'b0;
        end
        return r;
    endfunction

endpackage

// ----- hw/rtl/b64c_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64c_if
// Valid/ready channel interfaces: input items, result items, mode writes.
// ----------------------------------------------------------------------------
interface b64c_item_if;
    logic                        valid;
    logic                        ready;
    logic [b64c_pkg::BYTE_W-1:0] data_byte;
    logic                        message_end;

    modport source (output valid, output data_byte, output message_end, input ready);
    modport sink   (input valid, input data_byte, input message_end, output ready);
endinterface

interface b64c_result_if;
    logic                        valid;
    logic                        ready;
    logic [b64c_pkg::BYTE_W-1:0] out_byte;
    logic                        no_data;
    logic                        run_last;
    logic                        message_done;
    logic                        bad_char;

    modport source (output valid, output out_byte, output no_data, output run_last,
                    output message_done, output bad_char, input ready);
    modport sink   (input valid, input out_byte, input no_data, input run_last,
                    input message_done, input bad_char, output ready);
endinterface

interface b64c_cfg_if;
    logic valid;
    logic ready;
    logic decode_mode;

    modport source (output valid, output decode_mode, input ready);
    modport sink   (input valid, input decode_mode, output ready);
endinterface

// ----- hw/rtl/base64_codec_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// base64_codec_unit
// Streaming Base64 encoder/decoder (standard alphabet, '=' padding).
//
//   Channel  Dir   Payload                                         Handshake
//   item     in    data_byte, message_end                          valid/ready
//   result   out   out_byte, no_data, run_last, message_done,      valid/ready
//                  bad_char
//   cfg      in    decode_mode                                     valid/ready
//
// An item is registered, then translated combinationally into up to four results
// held in a result buffer that drains one result per cycle while result is ready.
// An item that gives no data but ends a message or holds a bad character gives
// one flag result. A steady encode stream gives four characters per three bytes,
// a message's last byte up to four; decode takes one item per cycle while ready.
// Reset clears control state and selects encode mode; cfg is always ready.
// Stalls on result hold the buffer and, once full, the input register.
// ----------------------------------------------------------------------------
module base64_codec_unit
(
    input  logic           clk,
    input  logic           rst_n,
    b64c_item_if.sink      item,
    b64c_result_if.source  result,
    b64c_cfg_if.sink       cfg
);

    // Input register
    logic                        in_vld_reg;
    logic [b64c_pkg::BYTE_W-1:0] in_byte_reg;
    logic                        in_end_reg;

    // Codec state
    b64c_pkg::mode_t               mode_reg;
    b64c_pkg::phase_t              phase_reg;
    b64c_pkg::phase_t              phase_next;
    logic [b64c_pkg::SEXTET_W-1:0] pend_reg;
    logic [b64c_pkg::SEXTET_W-1:0] pend_next;
    logic                          pad_seen_reg;
    logic                          pad_seen_next;

    // Result buffer
    logic [b64c_pkg::BYTE_W-1:0]    vals_reg  [b64c_pkg::MAX_RESULTS];
    logic [b64c_pkg::BYTE_W-1:0]    vals_next [b64c_pkg::MAX_RESULTS];
    logic [b64c_pkg::RES_CNT_W-1:0] rem_reg;
    logic [b64c_pkg::RES_CNT_W-1:0] rem_next;
    logic [b64c_pkg::RES_IDX_W-1:0] pos_reg;
    b64c_pkg::item_flags_t          flags_reg;
    b64c_pkg::item_flags_t          flags_next;

    logic                        in_fire;
    logic                        out_fire;
    logic                        cfg_fire;
    logic                        buf_free;
    logic                        load;
    b64c_pkg::sextet_lookup_t    lookup;

    assign out_fire = result.valid & result.ready;
    assign in_fire  = item.valid & item.ready;
    assign cfg_fire = cfg.valid & cfg.ready;
    assign cfg.ready = 1'b1;

    assign buf_free   = (rem_reg == '0) || ((rem_reg == 3'd1) && out_fire);
    assign load       = in_vld_reg & buf_free;
    assign item.ready = ~in_vld_reg | load;

    assign lookup = b64c_pkg::char_to_sextet(in_byte_reg);

    always_comb
    begin
        logic [b64c_pkg::RES_CNT_W-1:0] n;
        logic [b64c_pkg::BYTE_W-1:0]    b;
        n             = '0;
        b             = in_byte_reg;
        phase_next    = phase_reg;
        pend_next     = pend_reg;
        pad_seen_next = pad_seen_reg;
        flags_next    = '0;
        for (int i = 0; i < b64c_pkg::MAX_RESULTS; i++)
        begin
            vals_next[i] = '0;
        end

        if (mode_reg == b64c_pkg::MODE_ENCODE)
        begin
            unique case (phase_reg)
                b64c_pkg::PHASE_1:
                begin
                    vals_next[0] = b64c_pkg::sextet_to_char(pend_reg | {2'b00, b[7:4]});
                    pend_next    = {b[3:0], 2'b00};
                    phase_next   = b64c_pkg::PHASE_2;
                    n            = 3'd1;
                end
                b64c_pkg::PHASE_2:
                begin
                    vals_next[0] = b64c_pkg::sextet_to_char(pend_reg | {4'b0000, b[7:6]});
                    vals_next[1] = b64c_pkg::sextet_to_char(b[5:0]);
                    pend_next    = '0;
                    phase_next   = b64c_pkg::PHASE_0;
                    n            = 3'd2;
                end
                b64c_pkg::PHASE_0,
                b64c_pkg::PHASE_3:
                begin
                    vals_next[0] = b64c_pkg::sextet_to_char(b[7:2]);
                    pend_next    = {b[1:0], 4'b0000};
                    phase_next   = b64c_pkg::PHASE_1;
                    n            = 3'd1;
                end
            endcase
            // Flush the pending bits and pad the group out to four characters
            if (in_end_reg && (phase_next != b64c_pkg::PHASE_0))
            begin
                vals_next[n[1:0]] = b64c_pkg::sextet_to_char(pend_next);
                n = n + 3'd1;
                if (phase_next == b64c_pkg::PHASE_1)
                begin
                    vals_next[n[1:0]] = b64c_pkg::PAD_CHAR;
                    n = n + 3'd1;
                end
                vals_next[n[1:0]] = b64c_pkg::PAD_CHAR;
                n = n + 3'd1;
            end
        end
        else
        begin
            if (b == b64c_pkg::PAD_CHAR)
            begin
                pad_seen_next = 1'b1;
            end
            else if (!lookup.valid)
            begin
                flags_next.bad = 1'b1;
            end
            else if (!pad_seen_reg)
            begin
                unique case (phase_reg)
                    b64c_pkg::PHASE_0:
                    begin
                        pend_next  = lookup.sextet;
                        phase_next = b64c_pkg::PHASE_1;
                    end
                    b64c_pkg::PHASE_1:
                    begin
                        vals_next[0] = {pend_reg, lookup.sextet[5:4]};
                        pend_next    = {2'b00, lookup.sextet[3:0]};
                        phase_next   = b64c_pkg::PHASE_2;
                        n            = 3'd1;
                    end
                    b64c_pkg::PHASE_2:
                    begin
                        vals_next[0] = {pend_reg[3:0], lookup.sextet[5:2]};
                        pend_next    = {4'b0000, lookup.sextet[1:0]};
                        phase_next   = b64c_pkg::PHASE_3;
                        n            = 3'd1;
                    end
                    b64c_pkg::PHASE_3:
                    begin
                        vals_next[0] = {pend_reg[1:0], lookup.sextet};
                        pend_next    = '0;
                        phase_next   = b64c_pkg::PHASE_0;
                        n            = 3'd1;
                    end
                endcase
            end
        end

        // Emit a lone flag result when nothing else marks the transaction
        if ((n == '0) && (in_end_reg || flags_next.bad))
        begin
            flags_next.marker = 1'b1;
            n = 3'd1;
        end
        flags_next.msg_end = in_end_reg;
        if (in_end_reg)
        begin
            phase_next    = b64c_pkg::PHASE_0;
            pend_next     = '0;
            pad_seen_next = 1'b0;
        end

        rem_next = n;
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg   <= 1'b0;
            mode_reg     <= b64c_pkg::MODE_ENCODE;
            phase_reg    <= b64c_pkg::PHASE_0;
            pend_reg     <= '0;
            pad_seen_reg <= 1'b0;
            rem_reg      <= '0;
            pos_reg      <= '0;
        end
        else
        begin
            if (in_fire)
            begin
                in_vld_reg <= 1'b1;
            end
            else if (load)
            begin
                in_vld_reg <= 1'b0;
            end

            if (cfg_fire)
            begin
                mode_reg     <= b64c_pkg::mode_t'(cfg.decode_mode);
                phase_reg    <= b64c_pkg::PHASE_0;
                pend_reg     <= '0;
                pad_seen_reg <= 1'b0;
            end
            else if (load)
            begin
                phase_reg    <= phase_next;
                pend_reg     <= pend_next;
                pad_seen_reg <= pad_seen_next;
            end

            if (load)
            begin
                rem_reg <= rem_next;
                pos_reg <= '0;
            end
            else if (out_fire)
            begin
                rem_reg <= rem_reg - 3'd1;
                pos_reg <= pos_reg + 2'd1;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            in_byte_reg <= item.data_byte;
            in_end_reg  <= item.message_end;
        end
        if (load)
        begin
            vals_reg  <= vals_next;
            flags_reg <= flags_next;
        end
    end

    assign result.valid        = (rem_reg != '0);
    assign result.out_byte     = vals_reg[pos_reg];
    assign result.no_data      = flags_reg.marker;
    assign result.run_last     = (rem_reg == 3'd1);
    assign result.message_done = (rem_reg == 3'd1) & flags_reg.msg_end;
    assign result.bad_char     = flags_reg.bad;

endmodule

// ----- verif/base64_stream_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// base64_stream_checker
// Watches the item, result and mode-write channels of the Base64 codec.
// Keeps its own copy of the codec state, works out the characters or bytes
// each accepted item must produce, and compares every accepted result, field
// by field, with the oldest outstanding expectation.
// ----------------------------------------------------------------------------
module base64_stream_checker
    import b64c_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    b64c_item_if    item,
    b64c_result_if  result,
    b64c_cfg_if     cfg,
    output int      errors,
    output int      pending,
    output int      items_seen,
    output int      results_seen
);

    typedef struct packed
    {
        logic [BYTE_W-1:0] out_byte;
        logic              no_data;
        logic              run_last;
        logic              message_done;
        logic              bad_char;
    } codec_output_t;

    codec_output_t       pending_outputs[$];
    logic [BYTE_W-1:0]   alphabet_char[64];
    int                  sextet_of_char[256];

    mode_t               mode;
    phase_t              phase;
    logic [SEXTET_W-1:0] carry_bits;
    logic                pad_seen;
    int                  err_cnt;
    int                  item_cnt;
    int                  result_cnt;

    initial
    begin
        string letters;
        letters = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
        for (int c = 0; c < 256; c++)
        begin
            sextet_of_char[c] = -1;
        end
        for (int i = 0; i < 64; i++)
        begin
            alphabet_char[i] = letters[i];
            sextet_of_char[letters[i]] = i;
        end
    end

    task automatic clear_codec_state();
        phase      = PHASE_0;
        carry_bits = '0;
        pad_seen   = 1'b0;
    endtask

    // Work out the outputs of one accepted item and advance the state.
    task automatic predict_codec_output(input logic [BYTE_W-1:0] b, input logic eom);
        logic [BYTE_W-1:0]   vals[$];
        logic                bad;
        logic                marker;
        int                  v;
        logic [SEXTET_W-1:0] u;
        codec_output_t       r;
        bad    = 1'b0;
        marker = 1'b0;
        if (mode == MODE_ENCODE)
        begin
            case (phase)
                PHASE_1:
                begin
                    vals.push_back(alphabet_char[carry_bits | {2'b00, b[7:4]}]);
                    carry_bits = {b[3:0], 2'b00};
                    phase      = PHASE_2;
                end
                PHASE_2:
                begin
                    vals.push_back(alphabet_char[carry_bits | {4'b0000, b[7:6]}]);
                    vals.push_back(alphabet_char[b[5:0]]);
                    carry_bits = '0;
                    phase      = PHASE_0;
                end
                default:
                begin
                    vals.push_back(alphabet_char[b[7:2]]);
                    carry_bits = {b[1:0], 4'b0000};
                    phase      = PHASE_1;
                end
            endcase
            // Flush the open group and pad it out to four characters.
            if (eom && phase != PHASE_0)
            begin
                vals.push_back(alphabet_char[carry_bits]);
                if (phase == PHASE_1)
                begin
                    vals.push_back(PAD_CHAR);
                end
                vals.push_back(PAD_CHAR);
            end
        end
        else
        begin
            v = sextet_of_char[b];
            if (b == PAD_CHAR)
            begin
                pad_seen = 1'b1;
            end
            else if (v < 0)
            begin
                bad = 1'b1;
            end
            else if (!pad_seen)
            begin
                u = v[SEXTET_W-1:0];
                case (phase)
                    PHASE_0:
                    begin
                        carry_bits = u;
                        phase      = PHASE_1;
                    end
                    PHASE_1:
                    begin
                        vals.push_back({carry_bits, u[5:4]});
                        carry_bits = {2'b00, u[3:0]};
                        phase      = PHASE_2;
                    end
                    PHASE_2:
                    begin
                        vals.push_back({carry_bits[3:0], u[5:2]});
                        carry_bits = {4'b0000, u[1:0]};
                        phase      = PHASE_3;
                    end
                    default:
                    begin
                        vals.push_back({carry_bits[1:0], u});
                        carry_bits = '0;
                        phase      = PHASE_0;
                    end
                endcase
            end
        end

        if (vals.size() == 0 && (eom || bad))
        begin
            vals.push_back('0);
            marker = 1'b1;
        end
        if (eom)
        begin
            clear_codec_state();
        end

        for (int k = 0; k < vals.size(); k++)
        begin
            r.out_byte     = vals[k];
            r.no_data      = marker;
            r.run_last     = (k == vals.size() - 1);
            r.message_done = (k == vals.size() - 1) && eom;
            r.bad_char     = bad;
            pending_outputs.push_back(r);
        end
    endtask

    task automatic flag_mismatch(input string field, input int exp_val, input int got_val);
        err_cnt++;
        $display("%0t: result %0d %s mismatch, expected 0x%0h, actual 0x%0h",
                 $time, result_cnt, field, exp_val, got_val);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        codec_output_t exp;
        if (!rst_n)
        begin
            mode = MODE_ENCODE;
            clear_codec_state();
            pending_outputs.delete();
            err_cnt    = 0;
            item_cnt   = 0;
            result_cnt = 0;
        end
        else
        begin
            if (result.valid && result.ready)
            begin
                if (pending_outputs.size() == 0)
                begin
                    err_cnt++;
                    $display("%0t: unexpected result, expected none, actual 0x%0h",
                             $time, result.out_byte);
                end
                else
                begin
                    exp = pending_outputs.pop_front();
                    if (result.out_byte !== exp.out_byte)
                        flag_mismatch("out_byte", exp.out_byte, result.out_byte);
                    if (result.no_data !== exp.no_data)
                        flag_mismatch("no_data", exp.no_data, result.no_data);
                    if (result.run_last !== exp.run_last)
                        flag_mismatch("run_last", exp.run_last, result.run_last);
                    if (result.message_done !== exp.message_done)
                        flag_mismatch("message_done", exp.message_done, result.message_done);
                    if (result.bad_char !== exp.bad_char)
                        flag_mismatch("bad_char", exp.bad_char, result.bad_char);
                end
                result_cnt++;
            end
            if (cfg.valid && cfg.ready)
            begin
                mode = mode_t'(cfg.decode_mode);
                clear_codec_state();
            end
            if (item.valid && item.ready)
            begin
                predict_codec_output(item.data_byte, item.message_end);
                item_cnt++;
            end
        end
        errors       <= err_cnt;
        pending      <= pending_outputs.size();
        items_seen   <= item_cnt;
        results_seen <= result_cnt;
    end

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the Base64 codec. Sends directed and random
// messages in both modes under several idle and stall mixes, including a long
// receiver hold-off, while the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_top;
    import b64c_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int HOLD_CYCLES  = 150;
    localparam int DRAIN_CYCLES = 10;
    localparam int PHASE_ITEMS  = 29;

    logic clk;
    logic rst_n;
    logic hold_request;
    int   send_idle_pct;
    int   stall_pct;
    int   items_sent;
    int   cycle_count;
    int   chk_errors;
    int   chk_pending;
    int   chk_items;
    int   chk_results;

    b64c_item_if   item_ch();
    b64c_result_if result_ch();
    b64c_cfg_if    cfg_ch();

    base64_codec_unit DUT
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    base64_stream_checker u_checker
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item_ch),
        .result       (result_ch),
        .cfg          (cfg_ch),
        .errors       (chk_errors),
        .pending      (chk_pending),
        .items_seen   (chk_items),
        .results_seen (chk_results)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count >= CYCLE_LIMIT)
            begin
                $display("Timeout after %0d cycles with %0d results outstanding",
                         cycle_count, chk_pending);
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // Result side: random stalls, plus one long hold-off on request.
    initial
    begin
        result_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                result_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            result_ch.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    task automatic send_item(input logic [BYTE_W-1:0] b, input logic eom);
        while ($urandom_range(99) < send_idle_pct)
        begin
            item_ch.valid <= 1'b0;
            @(posedge clk);
        end
        item_ch.valid       <= 1'b1;
        item_ch.data_byte   <= b;
        item_ch.message_end <= eom;
        @(posedge clk);
        while (!item_ch.ready) @(posedge clk);
        items_sent++;
    endtask

    // Drop valid and wait until no result is outstanding for a while.
    task automatic wait_quiet(input int cycles);
        int quiet;
        quiet = 0;
        item_ch.valid <= 1'b0;
        while (quiet < cycles)
        begin
            @(posedge clk);
            quiet = (chk_pending == 0 && !result_ch.valid) ? quiet + 1 : 0;
        end
    endtask

    task automatic write_mode(input mode_t m);
        wait_quiet(DRAIN_CYCLES);
        cfg_ch.valid       <= 1'b1;
        cfg_ch.decode_mode <= m;
        @(posedge clk);
        while (!cfg_ch.ready) @(posedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    function automatic logic [BYTE_W-1:0] pick_b64_char();
        int v;
        v = $urandom_range(63);
        if (v < 26)
            return 8'h41 + BYTE_W'(v);
        else if (v < 52)
            return 8'h61 + BYTE_W'(v - 26);
        else if (v < 62)
            return 8'h30 + BYTE_W'(v - 52);
        else if (v == 62)
            return PLUS_CHAR;
        return SLASH_CHAR;
    endfunction

    // One whole message; decode messages are mostly well formed.
    task automatic send_message(input mode_t m);
        logic [BYTE_W-1:0] msg[$];
        int                len;
        int                k;
        if (m == MODE_ENCODE)
        begin
            len = $urandom_range(1, 8);
            for (k = 0; k < len; k++)
            begin
                if ($urandom_range(9) == 0)
                    msg.push_back((k % 2) ? 8'hFF : 8'h00);
                else
                    msg.push_back(BYTE_W'($urandom_range(255)));
            end
        end
        else if ($urandom_range(99) < 80)
        begin
            len = $urandom_range(1, 10);
            for (k = 0; k < len; k++)
            begin
                msg.push_back(pick_b64_char());
            end
            if ($urandom_range(2) == 0)
            begin
                repeat ($urandom_range(1, 2)) msg.push_back(PAD_CHAR);
                // Characters after padding are skipped silently.
                if ($urandom_range(5) == 0)
                    msg.push_back(pick_b64_char());
            end
        end
        else
        begin
            len = $urandom_range(1, 6);
            for (k = 0; k < len; k++)
            begin
                msg.push_back(BYTE_W'($urandom_range(255)));
            end
        end
        for (k = 0; k < msg.size(); k++)
        begin
            send_item(msg[k], k == msg.size() - 1);
        end
    endtask

    initial
    begin
        int    idle_sched[4];
        int    stall_sched[4];
        int    target;
        mode_t m;
        idle_sched  = '{0, 49, 0, 11};
        stall_sched = '{0, 0, 49, 11};
        hold_request = 1'b0;
        send_idle_pct = 0;
        stall_pct = 0;
        items_sent = 0;
        item_ch.valid       <= 1'b0;
        item_ch.data_byte   <= '0;
        item_ch.message_end <= 1'b0;
        cfg_ch.valid        <= 1'b0;
        cfg_ch.decode_mode  <= MODE_ENCODE;
        rst_n               <= 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Encode: single byte, two bytes, full group, '+' output, mode clear.
        write_mode(MODE_ENCODE);
        send_item(8'h00, 1'b1);
        send_item(8'hFF, 1'b0);
        send_item(8'hFF, 1'b1);
        send_item(8'h00, 1'b0);
        send_item(8'hFF, 1'b0);
        send_item(8'h80, 1'b1);
        send_item(8'hFB, 1'b0);
        send_item(8'hEF, 1'b0);
        send_item(8'hBE, 1'b1);
        send_item(8'h4D, 1'b0);
        write_mode(MODE_ENCODE);
        send_item(8'h4D, 1'b1);

        // Decode: full group, padding then skipped char, bad chars, lone char.
        write_mode(MODE_DECODE);
        send_item("Q", 1'b0);
        send_item("U", 1'b0);
        send_item("J", 1'b0);
        send_item("D", 1'b1);
        send_item("Y", 1'b0);
        send_item("Q", 1'b0);
        send_item(PAD_CHAR, 1'b0);
        send_item(PAD_CHAR, 1'b0);
        send_item("A", 1'b1);
        send_item(8'h00, 1'b0);
        send_item(8'hFF, 1'b1);
        send_item("z", 1'b1);
        send_item(PLUS_CHAR, 1'b0);
        send_item(SLASH_CHAR, 1'b1);
        send_item("Q", 1'b0);
        write_mode(MODE_DECODE);
        send_item("Q", 1'b0);
        send_item("U", 1'b1);

        for (int p = 0; p < 8; p++)
        begin
            m = (p % 2 == 1) ? MODE_DECODE : MODE_ENCODE;
            write_mode(m);
            send_idle_pct = idle_sched[p / 2];
            stall_pct     = stall_sched[p / 2];
            target = items_sent + PHASE_ITEMS;
            while (items_sent < target) send_message(m);
        end

        // Hold the result side off while items keep coming.
        send_idle_pct = 0;
        stall_pct     = 0;
        write_mode(MODE_ENCODE);
        hold_request = 1'b1;
        target = items_sent + 30;
        while (items_sent < target) send_message(MODE_ENCODE);

        wait_quiet(20);
        $display("Sent %0d items, checked %0d results in encode and decode modes,",
                 chk_items, chk_results);
        $display("with padding, bad characters, mode clears, idling and a long hold-off.");
        if (chk_errors == 0 && chk_pending == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ----- sim.f -----
hw/rtl/b64c_pkg.sv
hw/rtl/b64c_if.sv
hw/rtl/base64_codec_unit.sv
verif/base64_stream_checker.sv
verif/tb_top.sv
